// ===== hw/rtl/sfh_pkg.sv =====
// Shared types and constants of the segregated-fit heap allocator.
package sfh_pkg;

    localparam int CHUNK_BYTES = 4096;
    localparam int CHUNK_LOG2 = 12;
    localparam int MIN_BLOCK = 16;
    localparam int PROLOGUE_TAG = 9;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE = 1'b1;

    localparam logic [1:0] STAT_DONE = 2'd0;
    localparam logic [1:0] STAT_OOM = 2'd1;
    localparam logic [1:0] STAT_ZERO = 2'd2;

    typedef struct packed {
        logic [31:0] raddr;
        logic        we;
        logic [31:0] waddr;
        logic [31:0] wdata;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } alu_req_t;

endpackage

// ===== hw/rtl/sfh_alu.sv =====
// Shared 32-bit adder and subtractor with carry out.
module sfh_alu import sfh_pkg::*;
(
    input  alu_req_t    req,
    output logic [32:0] y
);

    always_comb
    begin
        if (req.sub)
        begin
            y = {1'b0, req.a} - {1'b0, req.b};
        end
        else
        begin
            y = {1'b0, req.a} + {1'b0, req.b};
        end
    end

endmodule

// ===== hw/rtl/sfh_heap_mem.sv =====
// Heap word memory with its initializing pass after reset.
module sfh_heap_mem import sfh_pkg::*;
#(
    parameter int NWORDS = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  mem_req_t    req,
    output logic [31:0] rdata,
    output logic        busy
);

    localparam int IW = $clog2(NWORDS);
    localparam int W_HDR = 3;
    localparam int W_FTR = (CHUNK_BYTES + 8) / 4;
    localparam int W_EPI = (CHUNK_BYTES + 12) / 4;

    logic [31:0] mem [NWORDS];
    logic [31:0] raw_reg;
    logic        oob_reg;
    logic        busy_reg;
    logic [IW-1:0] clr_reg;
    logic [IW-1:0] clr_next;
    logic        busy_next;
    logic        rd_in;
    logic        wr_in;
    logic        we_int;
    logic [IW-1:0] widx;
    logic [31:0] wval;
    logic [31:0] init_val;

    assign rd_in = ({2'b00, req.raddr[31:2]} < NWORDS);
    assign wr_in = ({2'b00, req.waddr[31:2]} < NWORDS);

    always_comb
    begin
        priority if (clr_reg == IW'(1) || clr_reg == IW'(2))
        begin
            init_val = 32'(PROLOGUE_TAG);
        end
        else if (clr_reg == IW'(W_HDR) || clr_reg == IW'(W_FTR))
        begin
            init_val = 32'(CHUNK_BYTES);
        end
        else if (clr_reg == IW'(W_EPI))
        begin
            init_val = 32'd1;
        end
        else
        begin
            init_val = '0;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        clr_next = clr_reg;
        if (busy_reg)
        begin
            we_int = 1'b1;
            widx = clr_reg;
            wval = init_val;
            clr_next = clr_reg + 1'b1;
            if (clr_reg == IW'(NWORDS - 1))
            begin
                busy_next = 1'b0;
            end
        end
        else
        begin
            we_int = req.we && wr_in;
            widx = req.waddr[IW+1:2];
            wval = req.wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            clr_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            clr_reg <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_int)
        begin
            mem[widx] <= wval;
        end
        raw_reg <= mem[req.raddr[IW+1:2]];
        oob_reg <= !rd_in;
    end

    assign rdata = oob_reg ? '0 : raw_reg;
    assign busy = busy_reg;

endmodule

// ===== hw/rtl/sfh_link_mem.sv =====
// Free-list successor memory, one entry per 8-byte slot.
module sfh_link_mem import sfh_pkg::*;
#(
    parameter int NSLOTS = 8192
)
(
    input  logic        clk,
    input  mem_req_t    req,
    output logic [31:0] rdata
);

    localparam int LW = $clog2(NSLOTS);

    logic [31:0] mem [NSLOTS];
    logic [31:0] raw_reg;
    logic        oob_reg;
    logic        rd_in;
    logic        wr_in;

    assign rd_in = ({3'b000, req.raddr[31:3]} < NSLOTS);
    assign wr_in = ({3'b000, req.waddr[31:3]} < NSLOTS);

    always_ff @(posedge clk)
    begin
        if (req.we && wr_in)
        begin
            mem[req.waddr[LW+2:3]] <= req.wdata;
        end
        raw_reg <= mem[req.raddr[LW+2:3]];
        oob_reg <= !rd_in;
    end

    assign rdata = oob_reg ? '0 : raw_reg;

endmodule

// ===== hw/rtl/segregated_fit_heap_allocator_unit.sv =====
// Top level: request sequencer of the segregated-fit heap allocator.
//
// Requests arrive on the s_ channel: s_tuser is the request type (allocate or
// free), s_tdata carries the requested byte count and the block offset to free.
// Each request gives exactly one result transfer on the m_ channel: m_tdata is
// the payload offset, m_tuser the status (done, out of memory, zero size).
// After reset the heap memory is written with its initial image, one word per
// cycle; s_tready stays low during that pass. A request is worked by a
// sequencer around one shared adder and heap and link memories that each have
// one read and one write port, with registered reads. A rejected free ends
// after its header or footer check; a valid free also walks a free list for
// each neighbour that it unlinks. An allocate walks the free lists from its
// size class upward, and a growth adds a merge and its own list walks. The
// finished result sits in an output register, so s_tready rises again while
// m_tvalid waits; a further result waits in the sequencer until the output
// register is free.
module segregated_fit_heap_allocator_unit import sfh_pkg::*;
#(
    parameter int HEAP_BYTES = 65536,
    parameter int SIZE_CLASSES = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,  // request_bytes[15:0], block_offset[31:16]
    input  logic        s_tuser,  // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // result_offset[15:0]
    output logic [1:0]  m_tuser   // status[1:0]
);

    localparam int NWORDS = HEAP_BYTES / 4;
    localparam int NSLOTS = HEAP_BYTES / 8;
    localparam int CLW = $clog2(SIZE_CLASSES + 1);
    localparam int CIW = $clog2(SIZE_CLASSES);
    localparam int SW = $clog2(NSLOTS + 2);
    localparam int HEW = $clog2(HEAP_BYTES + 1);
    localparam int INIT_CLASS = (CHUNK_LOG2 < SIZE_CLASSES - 1) ? CHUNK_LOG2 : SIZE_CLASSES - 1;
    localparam logic [CLW-1:0] NCLS = CLW'(SIZE_CLASSES);

    localparam logic [6:0] ST_INIT = 7'd0;
    localparam logic [6:0] ST_IDLE = 7'd1;
    localparam logic [6:0] ST_A_SIZE = 7'd2;
    localparam logic [6:0] ST_A_CLS = 7'd3;
    localparam logic [6:0] ST_F_HEAD = 7'd4;
    localparam logic [6:0] ST_F_CHK = 7'd5;
    localparam logic [6:0] ST_F_CMP = 7'd6;
    localparam logic [6:0] ST_P_RD = 7'd7;
    localparam logic [6:0] ST_P_CS = 7'd8;
    localparam logic [6:0] ST_P_W1 = 7'd9;
    localparam logic [6:0] ST_P_W2 = 7'd10;
    localparam logic [6:0] ST_P_W3 = 7'd11;
    localparam logic [6:0] ST_P_W4 = 7'd12;
    localparam logic [6:0] ST_P_W5 = 7'd13;
    localparam logic [6:0] ST_P_W6 = 7'd14;
    localparam logic [6:0] ST_P_W7 = 7'd15;
    localparam logic [6:0] ST_PU_RD = 7'd16;
    localparam logic [6:0] ST_PU_CLS = 7'd17;
    localparam logic [6:0] ST_PU_WR = 7'd18;
    localparam logic [6:0] ST_UL_RD = 7'd19;
    localparam logic [6:0] ST_UL_CLS = 7'd20;
    localparam logic [6:0] ST_UL_HEAD = 7'd21;
    localparam logic [6:0] ST_UL_CHK = 7'd22;
    localparam logic [6:0] ST_UL_CMP = 7'd23;
    localparam logic [6:0] ST_C_RD1 = 7'd24;
    localparam logic [6:0] ST_C_RD2 = 7'd25;
    localparam logic [6:0] ST_C_RD3 = 7'd26;
    localparam logic [6:0] ST_C_RD4 = 7'd27;
    localparam logic [6:0] ST_C_PB = 7'd28;
    localparam logic [6:0] ST_C_CASE = 7'd29;
    localparam logic [6:0] ST_C_A1 = 7'd30;
    localparam logic [6:0] ST_C_A2 = 7'd31;
    localparam logic [6:0] ST_C_A3 = 7'd32;
    localparam logic [6:0] ST_C_A4 = 7'd33;
    localparam logic [6:0] ST_C_A5 = 7'd34;
    localparam logic [6:0] ST_C_B1 = 7'd35;
    localparam logic [6:0] ST_C_B2 = 7'd36;
    localparam logic [6:0] ST_C_B3 = 7'd37;
    localparam logic [6:0] ST_C_B4 = 7'd38;
    localparam logic [6:0] ST_C_B5 = 7'd39;
    localparam logic [6:0] ST_C_N1 = 7'd40;
    localparam logic [6:0] ST_C_N2 = 7'd41;
    localparam logic [6:0] ST_C_N3 = 7'd42;
    localparam logic [6:0] ST_C_N4 = 7'd43;
    localparam logic [6:0] ST_C_N5 = 7'd44;
    localparam logic [6:0] ST_C_N6 = 7'd45;
    localparam logic [6:0] ST_C_N7 = 7'd46;
    localparam logic [6:0] ST_C_N8 = 7'd47;
    localparam logic [6:0] ST_C_END = 7'd48;
    localparam logic [6:0] ST_G_GROW = 7'd49;
    localparam logic [6:0] ST_G_CHK = 7'd50;
    localparam logic [6:0] ST_G_W1 = 7'd51;
    localparam logic [6:0] ST_G_W2 = 7'd52;
    localparam logic [6:0] ST_G_W3 = 7'd53;
    localparam logic [6:0] ST_G_W4 = 7'd54;
    localparam logic [6:0] ST_FR_RD = 7'd55;
    localparam logic [6:0] ST_FR_H = 7'd56;
    localparam logic [6:0] ST_FR_H2 = 7'd57;
    localparam logic [6:0] ST_FR_F = 7'd58;
    localparam logic [6:0] ST_FR_W2 = 7'd59;
    localparam logic [6:0] ST_DONE = 7'd60;

    function automatic logic [31:0] hs(input logic [31:0] w);
        return {w[31:3], 3'b000};
    endfunction

    function automatic logic [CLW-1:0] class_of(input logic [31:0] s);
        logic [4:0] p;
        p = '0;
        for (int i = 1; i < 32; i++)
        begin
            if (s[i])
            begin
                p = 5'(i);
            end
        end
        if (32'(p) > SIZE_CLASSES - 1)
        begin
            return CLW'(SIZE_CLASSES - 1);
        end
        return CLW'(p);
    endfunction

    logic [6:0]  state_reg, state_next;
    logic [6:0]  ret_reg, ret_next;
    logic        req_reg, req_next;
    logic [15:0] nbytes_reg, nbytes_next;
    logic [15:0] off_reg, off_next;
    logic [16:0] asize_reg, asize_next;
    logic [16:0] grow_reg, grow_next;
    logic [31:0] bp_reg, bp_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] osize_reg, osize_next;
    logic [31:0] csize_reg, csize_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] nb_reg, nb_next;
    logic [31:0] pb_reg, pb_next;
    logic [31:0] nsz_reg, nsz_next;
    logic [31:0] pw_reg, pw_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] t_reg, t_next;
    logic        carry_reg, carry_next;
    logic [31:0] arg_reg, arg_next;
    logic [31:0] cur_reg, cur_next;
    logic [31:0] prev_reg, prev_next;
    logic [SW-1:0] steps_reg, steps_next;
    logic [CLW-1:0] cls_reg, cls_next;
    logic        na_reg, na_next;
    logic        split_reg, split_next;
    logic        alloc_reg, alloc_next;
    logic [15:0] res_reg, res_next;
    logic [1:0]  stat_reg, stat_next;
    logic [HEW-1:0] heap_end_reg, heap_end_next;
    logic [31:0] heads_reg [SIZE_CLASSES];
    logic [31:0] heads_next [SIZE_CLASSES];
    logic        m_valid_reg, m_valid_next;
    logic [15:0] m_data_reg, m_data_next;
    logic [1:0]  m_user_reg, m_user_next;

    alu_req_t    alu_req;
    logic [32:0] alu_y;
    mem_req_t    heap_req;
    mem_req_t    link_req;
    logic [31:0] hrd;
    logic [31:0] lrd;
    logic        heap_busy;
    logic [31:0] hsz;
    logic [CIW-1:0] cidx;
    logic        walk_end;
    logic [31:0] tag_val;

    sfh_alu u_alu (
        .req (alu_req),
        .y   (alu_y)
    );

    sfh_heap_mem #(
        .NWORDS (NWORDS)
    ) u_heap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (heap_req),
        .rdata (hrd),
        .busy  (heap_busy)
    );

    sfh_link_mem #(
        .NSLOTS (NSLOTS)
    ) u_link (
        .clk   (clk),
        .req   (link_req),
        .rdata (lrd)
    );

    assign hsz = hs(hrd);
    assign cidx = cls_reg[CIW-1:0];
    assign walk_end = (cur_reg == '0) || (32'(steps_reg) > NSLOTS);
    assign tag_val = split_reg ? ({15'b0, asize_reg} | 32'd1) : (csize_reg | 32'd1);

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata = m_data_reg;
    assign m_tuser = m_user_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next = ret_reg;
        req_next = req_reg;
        nbytes_next = nbytes_reg;
        off_next = off_reg;
        asize_next = asize_reg;
        grow_next = grow_reg;
        bp_next = bp_reg;
        size_next = size_reg;
        osize_next = osize_reg;
        csize_next = csize_reg;
        rem_next = rem_reg;
        nb_next = nb_reg;
        pb_next = pb_reg;
        nsz_next = nsz_reg;
        pw_next = pw_reg;
        h_next = h_reg;
        t_next = t_reg;
        carry_next = carry_reg;
        arg_next = arg_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        steps_next = steps_reg;
        cls_next = cls_reg;
        na_next = na_reg;
        split_next = split_reg;
        alloc_next = alloc_reg;
        res_next = res_reg;
        stat_next = stat_reg;
        heap_end_next = heap_end_reg;
        heads_next = heads_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;

        alu_req = '{a: '0, b: '0, sub: 1'b0};
        heap_req = '{raddr: alu_y[31:0], we: 1'b0, waddr: alu_y[31:0], wdata: '0};
        link_req = '{raddr: cur_reg, we: 1'b0, waddr: prev_reg, wdata: lrd};

        unique case (state_reg)
            ST_INIT:
            begin
                link_req.we = 1'b1;
                link_req.waddr = 32'(MIN_BLOCK);
                link_req.wdata = '0;
                if (!heap_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    req_next = s_tuser;
                    nbytes_next = s_tdata[15:0];
                    off_next = s_tdata[31:16];
                    state_next = (s_tuser == REQ_FREE) ? ST_FR_RD : ST_A_SIZE;
                end
            end
            ST_A_SIZE:
            begin
                alu_req = '{a: {16'b0, nbytes_reg}, b: 32'd15, sub: 1'b0};
                if (nbytes_reg == '0)
                begin
                    res_next = '0;
                    stat_next = STAT_ZERO;
                    state_next = ST_DONE;
                end
                else
                begin
                    asize_next = (nbytes_reg <= 16'd8) ? 17'(MIN_BLOCK)
                                                       : {alu_y[16:3], 3'b000};
                    state_next = ST_A_CLS;
                end
            end
            ST_A_CLS:
            begin
                cls_next = class_of({15'b0, asize_reg});
                state_next = ST_F_HEAD;
            end
            ST_F_HEAD:
            begin
                if (cls_reg == NCLS)
                begin
                    state_next = ST_G_GROW;
                end
                else
                begin
                    cur_next = heads_reg[cidx];
                    prev_next = '0;
                    steps_next = '0;
                    state_next = ST_F_CHK;
                end
            end
            ST_F_CHK:
            begin
                alu_req = '{a: cur_reg, b: 32'd4, sub: 1'b1};
                if (walk_end)
                begin
                    cls_next = cls_reg + 1'b1;
                    state_next = ST_F_HEAD;
                end
                else
                begin
                    state_next = ST_F_CMP;
                end
            end
            ST_F_CMP:
            begin
                if (hsz >= {15'b0, asize_reg})
                begin
                    if (prev_reg == '0)
                    begin
                        heads_next[cidx] = lrd;
                    end
                    else
                    begin
                        link_req.we = 1'b1;
                    end
                    bp_next = cur_reg;
                    state_next = ST_P_RD;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next = lrd;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_F_CHK;
                end
            end
            ST_P_RD:
            begin
                alu_req = '{a: bp_reg, b: 32'd4, sub: 1'b1};
                res_next = bp_reg[15:0];
                stat_next = STAT_DONE;
                state_next = ST_P_CS;
            end
            ST_P_CS:
            begin
                alu_req = '{a: {15'b0, asize_reg}, b: 32'(MIN_BLOCK), sub: 1'b0};
                csize_next = hsz;
                split_next = (hsz >= alu_y[31:0]);
                state_next = ST_P_W1;
            end
            ST_P_W1:
            begin
                alu_req = '{a: bp_reg, b: 32'd4, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = tag_val;
                state_next = ST_P_W2;
            end
            ST_P_W2:
            begin
                alu_req = '{a: bp_reg, b: split_reg ? {15'b0, asize_reg} : csize_reg,
                            sub: 1'b0};
                t_next = alu_y[31:0];
                state_next = ST_P_W3;
            end
            ST_P_W3:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = tag_val;
                state_next = split_reg ? ST_P_W4 : ST_DONE;
            end
            ST_P_W4:
            begin
                alu_req = '{a: csize_reg, b: {15'b0, asize_reg}, sub: 1'b1};
                rem_next = alu_y[31:0];
                state_next = ST_P_W5;
            end
            ST_P_W5:
            begin
                alu_req = '{a: t_reg, b: 32'd4, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = rem_reg;
                arg_next = t_reg;
                state_next = ST_P_W6;
            end
            ST_P_W6:
            begin
                alu_req = '{a: t_reg, b: rem_reg, sub: 1'b0};
                t_next = alu_y[31:0];
                state_next = ST_P_W7;
            end
            ST_P_W7:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = rem_reg;
                ret_next = ST_DONE;
                state_next = ST_PU_RD;
            end
            ST_PU_RD:
            begin
                alu_req = '{a: arg_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_PU_CLS;
            end
            ST_PU_CLS:
            begin
                cls_next = class_of(hsz);
                state_next = ST_PU_WR;
            end
            ST_PU_WR:
            begin
                link_req.we = 1'b1;
                link_req.waddr = arg_reg;
                link_req.wdata = heads_reg[cidx];
                heads_next[cidx] = arg_reg;
                state_next = ret_reg;
            end
            ST_UL_RD:
            begin
                alu_req = '{a: arg_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_UL_CLS;
            end
            ST_UL_CLS:
            begin
                cls_next = class_of(hsz);
                state_next = ST_UL_HEAD;
            end
            ST_UL_HEAD:
            begin
                cur_next = heads_reg[cidx];
                prev_next = '0;
                steps_next = '0;
                state_next = ST_UL_CHK;
            end
            ST_UL_CHK:
            begin
                state_next = walk_end ? ret_reg : ST_UL_CMP;
            end
            ST_UL_CMP:
            begin
                if (cur_reg == arg_reg)
                begin
                    if (prev_reg == '0)
                    begin
                        heads_next[cidx] = lrd;
                    end
                    else
                    begin
                        link_req.we = 1'b1;
                    end
                    state_next = ret_reg;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next = lrd;
                    steps_next = steps_reg + 1'b1;
                    state_next = ST_UL_CHK;
                end
            end
            ST_C_RD1:
            begin
                alu_req = '{a: bp_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_C_RD2;
            end
            ST_C_RD2:
            begin
                alu_req = '{a: bp_reg, b: 32'd8, sub: 1'b1};
                size_next = hsz;
                osize_next = hsz;
                state_next = ST_C_RD3;
            end
            ST_C_RD3:
            begin
                alu_req = '{a: bp_reg, b: size_reg, sub: 1'b0};
                pw_next = hrd;
                nb_next = alu_y[31:0];
                state_next = ST_C_RD4;
            end
            ST_C_RD4:
            begin
                alu_req = '{a: nb_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_C_PB;
            end
            ST_C_PB:
            begin
                alu_req = '{a: bp_reg, b: hs(pw_reg), sub: 1'b1};
                na_next = hrd[0];
                pb_next = alu_y[31:0];
                state_next = ST_C_CASE;
            end
            ST_C_CASE:
            begin
                priority if (pw_reg[0] && na_reg)
                begin
                    arg_next = bp_reg;
                    ret_next = ST_C_END;
                    state_next = ST_PU_RD;
                end
                else if (pw_reg[0])
                begin
                    arg_next = nb_reg;
                    ret_next = ST_C_A1;
                    state_next = ST_UL_RD;
                end
                else if (na_reg)
                begin
                    arg_next = pb_reg;
                    ret_next = ST_C_B1;
                    state_next = ST_UL_RD;
                end
                else
                begin
                    arg_next = pb_reg;
                    ret_next = ST_C_N1;
                    state_next = ST_UL_RD;
                end
            end
            ST_C_A1:
            begin
                alu_req = '{a: nb_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_C_A2;
            end
            ST_C_A2:
            begin
                alu_req = '{a: size_reg, b: hsz, sub: 1'b0};
                size_next = alu_y[31:0];
                state_next = ST_C_A3;
            end
            ST_C_A3:
            begin
                alu_req = '{a: bp_reg, b: 32'd4, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = size_reg;
                state_next = ST_C_A4;
            end
            ST_C_A4:
            begin
                alu_req = '{a: bp_reg, b: size_reg, sub: 1'b0};
                t_next = alu_y[31:0];
                state_next = ST_C_A5;
            end
            ST_C_A5:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = size_reg;
                arg_next = bp_reg;
                ret_next = ST_C_END;
                state_next = ST_PU_RD;
            end
            ST_C_B1:
            begin
                alu_req = '{a: pb_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_C_B2;
            end
            ST_C_B2:
            begin
                alu_req = '{a: size_reg, b: hsz, sub: 1'b0};
                size_next = alu_y[31:0];
                state_next = ST_C_B3;
            end
            ST_C_B3:
            begin
                alu_req = '{a: bp_reg, b: osize_reg, sub: 1'b0};
                t_next = alu_y[31:0];
                state_next = ST_C_B4;
            end
            ST_C_B4:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = size_reg;
                state_next = ST_C_B5;
            end
            ST_C_B5:
            begin
                alu_req = '{a: pb_reg, b: 32'd4, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = size_reg;
                bp_next = pb_reg;
                arg_next = pb_reg;
                ret_next = ST_C_END;
                state_next = ST_PU_RD;
            end
            ST_C_N1:
            begin
                arg_next = nb_reg;
                ret_next = ST_C_N2;
                state_next = ST_UL_RD;
            end
            ST_C_N2:
            begin
                alu_req = '{a: nb_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_C_N3;
            end
            ST_C_N3:
            begin
                alu_req = '{a: size_reg, b: hsz, sub: 1'b0};
                nsz_next = hsz;
                size_next = alu_y[31:0];
                state_next = ST_C_N4;
            end
            ST_C_N4:
            begin
                alu_req = '{a: pb_reg, b: 32'd4, sub: 1'b1};
                state_next = ST_C_N5;
            end
            ST_C_N5:
            begin
                alu_req = '{a: size_reg, b: hsz, sub: 1'b0};
                size_next = alu_y[31:0];
                state_next = ST_C_N6;
            end
            ST_C_N6:
            begin
                alu_req = '{a: pb_reg, b: 32'd4, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = size_reg;
                state_next = ST_C_N7;
            end
            ST_C_N7:
            begin
                alu_req = '{a: nb_reg, b: nsz_reg, sub: 1'b0};
                t_next = alu_y[31:0];
                state_next = ST_C_N8;
            end
            ST_C_N8:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = size_reg;
                bp_next = pb_reg;
                arg_next = pb_reg;
                ret_next = ST_C_END;
                state_next = ST_PU_RD;
            end
            ST_C_END:
            begin
                if (alloc_reg)
                begin
                    arg_next = bp_reg;
                    ret_next = ST_P_RD;
                    state_next = ST_UL_RD;
                end
                else
                begin
                    res_next = off_reg;
                    stat_next = STAT_DONE;
                    state_next = ST_DONE;
                end
            end
            ST_G_GROW:
            begin
                grow_next = (asize_reg > 17'(CHUNK_BYTES)) ? asize_reg : 17'(CHUNK_BYTES);
                state_next = ST_G_CHK;
            end
            ST_G_CHK:
            begin
                alu_req = '{a: 32'(heap_end_reg), b: {15'b0, grow_reg}, sub: 1'b0};
                if (alu_y > 33'(HEAP_BYTES))
                begin
                    res_next = '0;
                    stat_next = STAT_OOM;
                    state_next = ST_DONE;
                end
                else
                begin
                    bp_next = 32'(heap_end_reg);
                    state_next = ST_G_W1;
                end
            end
            ST_G_W1:
            begin
                alu_req = '{a: bp_reg, b: 32'd4, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = {15'b0, grow_reg};
                state_next = ST_G_W2;
            end
            ST_G_W2:
            begin
                alu_req = '{a: bp_reg, b: {15'b0, grow_reg}, sub: 1'b0};
                t_next = alu_y[31:0];
                state_next = ST_G_W3;
            end
            ST_G_W3:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = {15'b0, grow_reg};
                state_next = ST_G_W4;
            end
            ST_G_W4:
            begin
                alu_req = '{a: t_reg, b: 32'd4, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = 32'd1;
                heap_end_next = t_reg[HEW-1:0];
                alloc_next = 1'b1;
                state_next = ST_C_RD1;
            end
            ST_FR_RD:
            begin
                alu_req = '{a: {16'b0, off_reg}, b: 32'd4, sub: 1'b1};
                state_next = ST_FR_H;
            end
            ST_FR_H:
            begin
                alu_req = '{a: {16'b0, off_reg}, b: hsz, sub: 1'b0};
                h_next = hrd;
                t_next = alu_y[31:0];
                carry_next = alu_y[32];
                state_next = ST_FR_H2;
            end
            ST_FR_H2:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                if (off_reg >= 16'(MIN_BLOCK) && h_reg[0] && hs(h_reg) >= 32'(MIN_BLOCK)
                    && !carry_reg && t_reg <= 32'(heap_end_reg))
                begin
                    state_next = ST_FR_F;
                end
                else
                begin
                    res_next = '0;
                    stat_next = STAT_DONE;
                    state_next = ST_DONE;
                end
            end
            ST_FR_F:
            begin
                alu_req = '{a: {16'b0, off_reg}, b: 32'd4, sub: 1'b1};
                if (hrd != h_reg)
                begin
                    res_next = '0;
                    stat_next = STAT_DONE;
                    state_next = ST_DONE;
                end
                else
                begin
                    heap_req.we = 1'b1;
                    heap_req.wdata = hs(h_reg);
                    state_next = ST_FR_W2;
                end
            end
            ST_FR_W2:
            begin
                alu_req = '{a: t_reg, b: 32'd8, sub: 1'b1};
                heap_req.we = 1'b1;
                heap_req.wdata = hs(h_reg);
                bp_next = {16'b0, off_reg};
                alloc_next = 1'b0;
                state_next = ST_C_RD1;
            end
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next = res_reg;
                    m_user_next = stat_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ret_reg <= ST_DONE;
            heap_end_reg <= HEW'(MIN_BLOCK + CHUNK_BYTES);
            for (int i = 0; i < SIZE_CLASSES; i++)
            begin
                heads_reg[i] <= (i == INIT_CLASS) ? 32'(MIN_BLOCK) : '0;
            end
            m_valid_reg <= 1'b0;
            alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            heap_end_reg <= heap_end_next;
            heads_reg <= heads_next;
            m_valid_reg <= m_valid_next;
            alloc_reg <= alloc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg <= req_next;
        nbytes_reg <= nbytes_next;
        off_reg <= off_next;
        asize_reg <= asize_next;
        grow_reg <= grow_next;
        bp_reg <= bp_next;
        size_reg <= size_next;
        osize_reg <= osize_next;
        csize_reg <= csize_next;
        rem_reg <= rem_next;
        nb_reg <= nb_next;
        pb_reg <= pb_next;
        nsz_reg <= nsz_next;
        pw_reg <= pw_next;
        h_reg <= h_next;
        t_reg <= t_next;
        carry_reg <= carry_next;
        arg_reg <= arg_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        steps_reg <= steps_next;
        cls_reg <= cls_next;
        na_reg <= na_next;
        split_reg <= split_next;
        res_reg <= res_next;
        stat_reg <= stat_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    a_heap_end_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(heap_end_reg) <= HEAP_BYTES)
        else $error("heap end beyond heap size");

    a_oom_no_offset: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == STAT_OOM |-> m_tdata == '0)
        else $error("out of memory result carries an offset");

    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> state_reg != ST_IDLE && state_reg != ST_INIT)
        else $error("accepted request was not started");

    a_free_kind: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FR_RD |-> req_reg == REQ_FREE)
        else $error("free sequence entered for an allocate request");

    a_valid_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == STAT_DONE || m_tuser == STAT_OOM || m_tuser == STAT_ZERO))
        else $error("undefined status code");

endmodule

// ===== dv/tb.sv =====
// Testbench for the segregated-fit heap allocator: predicts every result and checks it in order.
module tb;
    import sfh_pkg::*;

    localparam int HEAP_SIZE = 65536;
    localparam int N_CLASSES = 20;
    localparam int N_WORDS = HEAP_SIZE / 4;
    localparam int N_SLOTS = HEAP_SIZE / 8;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct {
        logic [15:0] offset;
        logic [1:0]  status;
    } heap_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;

    int unsigned  heap_mem [N_WORDS];
    int unsigned  list_heads [N_CLASSES];
    int unsigned  next_blk [N_SLOTS];
    int unsigned  brk;
    heap_result_t pending_results [$];
    int unsigned  live_blocks [$];
    int           errors;
    int           cycles;
    bit           calm;
    int           stall_gen;

    segregated_fit_heap_allocator_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int unsigned mem_rd(int unsigned a);
        int unsigned i;
        i = a >> 2;
        return (i < N_WORDS) ? heap_mem[i] : 0;
    endfunction

    function automatic void mem_wr(int unsigned a, int unsigned v);
        int unsigned i;
        i = a >> 2;
        if (i < N_WORDS)
        begin
            heap_mem[i] = v;
        end
    endfunction

    function automatic int unsigned blk_size(int unsigned bp);
        return mem_rd(bp - 4) & ~32'd7;
    endfunction

    function automatic int unsigned link_rd(int unsigned bp);
        int unsigned i;
        i = bp >> 3;
        return (i < N_SLOTS) ? next_blk[i] : 0;
    endfunction

    function automatic void link_wr(int unsigned bp, int unsigned v);
        int unsigned i;
        i = bp >> 3;
        if (i < N_SLOTS)
        begin
            next_blk[i] = v;
        end
    endfunction

    function automatic int unsigned size_class(int unsigned s);
        int unsigned c;
        c = 0;
        while (s > 1 && c < N_CLASSES - 1)
        begin
            s = s >> 1;
            c++;
        end
        return c;
    endfunction

    function automatic void list_push(int unsigned bp);
        int unsigned c;
        c = size_class(blk_size(bp));
        link_wr(bp, list_heads[c]);
        list_heads[c] = bp;
    endfunction

    function automatic void list_remove(int unsigned bp);
        int unsigned c;
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        c = size_class(blk_size(bp));
        prev = 0;
        cur = list_heads[c];
        steps = 0;
        while (cur != 0 && steps <= N_SLOTS)
        begin
            if (cur == bp)
            begin
                if (prev == 0)
                begin
                    list_heads[c] = link_rd(cur);
                end
                else
                begin
                    link_wr(prev, link_rd(cur));
                end
                return;
            end
            prev = cur;
            cur = link_rd(cur);
            steps++;
        end
    endfunction

    function automatic int unsigned merge_free(int unsigned bp);
        int unsigned size;
        int unsigned prev_used;
        int unsigned next_bp;
        int unsigned next_used;
        int unsigned prev_bp;
        int unsigned nsz;
        size = blk_size(bp);
        prev_used = mem_rd(bp - 8) & 1;
        next_bp = bp + size;
        next_used = mem_rd(next_bp - 4) & 1;
        prev_bp = bp - (mem_rd(bp - 8) & ~32'd7);
        if (prev_used != 0 && next_used != 0)
        begin
            list_push(bp);
            return bp;
        end
        if (prev_used != 0)
        begin
            list_remove(next_bp);
            size += blk_size(next_bp);
            mem_wr(bp - 4, size);
            mem_wr(bp + size - 8, size);
        end
        else if (next_used != 0)
        begin
            list_remove(prev_bp);
            size += blk_size(prev_bp);
            mem_wr(bp + blk_size(bp) - 8, size);
            mem_wr(prev_bp - 4, size);
            bp = prev_bp;
        end
        else
        begin
            list_remove(prev_bp);
            list_remove(next_bp);
            nsz = blk_size(next_bp);
            size += blk_size(prev_bp) + nsz;
            mem_wr(prev_bp - 4, size);
            mem_wr(next_bp + nsz - 8, size);
            bp = prev_bp;
        end
        list_push(bp);
        return bp;
    endfunction

    function automatic void carve(int unsigned bp, int unsigned asize);
        int unsigned csize;
        int unsigned rb;
        csize = blk_size(bp);
        if (csize >= asize + MIN_BLOCK)
        begin
            rb = bp + asize;
            mem_wr(bp - 4, asize | 1);
            mem_wr(bp + asize - 8, asize | 1);
            mem_wr(rb - 4, csize - asize);
            mem_wr(rb + (csize - asize) - 8, csize - asize);
            list_push(rb);
        end
        else
        begin
            mem_wr(bp - 4, csize | 1);
            mem_wr(bp + csize - 8, csize | 1);
        end
    endfunction

    function automatic int unsigned first_fit(int unsigned asize);
        int unsigned prev;
        int unsigned cur;
        int unsigned steps;
        for (int unsigned c = size_class(asize); c < N_CLASSES; c++)
        begin
            prev = 0;
            cur = list_heads[c];
            steps = 0;
            while (cur != 0 && steps <= N_SLOTS)
            begin
                if (blk_size(cur) >= asize)
                begin
                    if (prev == 0)
                    begin
                        list_heads[c] = link_rd(cur);
                    end
                    else
                    begin
                        link_wr(prev, link_rd(cur));
                    end
                    return cur;
                end
                prev = cur;
                cur = link_rd(cur);
                steps++;
            end
        end
        return 0;
    endfunction

    function automatic void heap_model_reset();
        foreach (heap_mem[i]) heap_mem[i] = 0;
        foreach (list_heads[i]) list_heads[i] = 0;
        foreach (next_blk[i]) next_blk[i] = 0;
        mem_wr(4, PROLOGUE_TAG);
        mem_wr(8, PROLOGUE_TAG);
        mem_wr(12, CHUNK_BYTES);
        mem_wr(16 + CHUNK_BYTES - 8, CHUNK_BYTES);
        mem_wr(16 + CHUNK_BYTES - 4, 1);
        brk = 16 + CHUNK_BYTES;
        list_push(16);
    endfunction

    function automatic heap_result_t heap_model_step(logic req, logic [15:0] nbytes,
                                                     logic [15:0] off);
        heap_result_t r;
        int unsigned asize;
        int unsigned bp;
        int unsigned grow;
        int unsigned h;
        int unsigned sz;
        r.offset = '0;
        r.status = STAT_DONE;
        if (req == REQ_ALLOC)
        begin
            if (nbytes == 0)
            begin
                r.status = STAT_ZERO;
            end
            else
            begin
                asize = (nbytes <= 8) ? MIN_BLOCK : 8 * ((int'(nbytes) + 15) / 8);
                bp = first_fit(asize);
                if (bp != 0)
                begin
                    carve(bp, asize);
                    r.offset = bp[15:0];
                end
                else
                begin
                    grow = (asize > CHUNK_BYTES) ? asize : CHUNK_BYTES;
                    if (longint'(brk) + grow > HEAP_SIZE)
                    begin
                        r.status = STAT_OOM;
                    end
                    else
                    begin
                        bp = brk;
                        mem_wr(bp - 4, grow);
                        mem_wr(bp + grow - 8, grow);
                        mem_wr(bp + grow - 4, 1);
                        brk += grow;
                        bp = merge_free(bp);
                        list_remove(bp);
                        carve(bp, asize);
                        r.offset = bp[15:0];
                    end
                end
            end
        end
        else
        begin
            h = mem_rd(int'(off) - 4);
            sz = h & ~32'd7;
            if (off >= MIN_BLOCK && (h & 1) != 0 && sz >= MIN_BLOCK &&
                longint'(off) + sz <= brk && mem_rd(int'(off) + sz - 8) == h)
            begin
                mem_wr(int'(off) - 4, sz);
                mem_wr(int'(off) + sz - 8, sz);
                void'(merge_free(off));
                r.offset = off;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("tb: mismatch on %s: got %0d, expected %0d", what, got, want);
        errors++;
    endtask

    task automatic send_req(logic req, logic [15:0] nbytes, logic [15:0] off,
                            output heap_result_t r);
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {off, nbytes};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        r = heap_model_step(req, nbytes, off);
        pending_results.push_back(r);
        if (req == REQ_ALLOC && r.status == STAT_DONE)
        begin
            live_blocks.push_back(r.offset);
        end
        if (!calm && $urandom_range(0, 99) < 32)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_free_live(int idx);
        heap_result_t r;
        int unsigned bp;
        bp = live_blocks[idx];
        live_blocks.delete(idx);
        send_req(REQ_FREE, 16'($urandom), bp[15:0], r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic test_directed();
        heap_result_t r;
        heap_result_t a;
        heap_result_t b;
        heap_result_t c;
        heap_result_t d;
        send_req(REQ_ALLOC, 16'd0, 16'hffff, r);
        send_req(REQ_ALLOC, 16'd1, 16'd0, r);
        send_req(REQ_ALLOC, 16'd8, 16'd0, r);
        send_req(REQ_ALLOC, 16'd9, 16'd0, r);
        send_req(REQ_ALLOC, 16'd40, 16'd0, a);
        send_req(REQ_ALLOC, 16'd40, 16'd0, b);
        send_req(REQ_ALLOC, 16'd40, 16'd0, c);
        send_req(REQ_ALLOC, 16'd40, 16'd0, d);
        send_req(REQ_FREE, 16'd0, b.offset, r);
        send_req(REQ_FREE, 16'd0, a.offset, r);
        send_req(REQ_FREE, 16'd0, d.offset, r);
        send_req(REQ_FREE, 16'd0, c.offset, r);
        send_req(REQ_FREE, 16'd0, a.offset, r);
        send_req(REQ_ALLOC, 16'd4096, 16'd0, r);
        send_req(REQ_ALLOC, 16'd65535, 16'd0, r);
        send_req(REQ_ALLOC, 16'd60000, 16'd0, r);
        send_req(REQ_FREE, 16'hffff, 16'd0, r);
        send_req(REQ_FREE, 16'd0, 16'd4, r);
        send_req(REQ_FREE, 16'd0, 16'hffff, r);
        send_req(REQ_FREE, 16'd0, r.offset + 16'd8, r);
        for (int i = live_blocks.size() - 1; i >= 0; i--)
        begin
            if (live_blocks[i] == a.offset || live_blocks[i] == b.offset ||
                live_blocks[i] == c.offset || live_blocks[i] == d.offset)
            begin
                live_blocks.delete(i);
            end
        end
    endtask

    task automatic random_item();
        heap_result_t r;
        int sel;
        logic [15:0] nbytes;
        sel = $urandom_range(0, 99);
        if (sel < 8)
        begin
            send_req(REQ_FREE, 16'($urandom), 16'($urandom), r);
        end
        else if (sel < 52 && live_blocks.size() != 0)
        begin
            send_free_live($urandom_range(0, live_blocks.size() - 1));
        end
        else
        begin
            sel = $urandom_range(0, 99);
            if (sel < 70)
                nbytes = 16'($urandom_range(1, 128));
            else if (sel < 90)
                nbytes = 16'($urandom_range(129, 1024));
            else if (sel < 97)
                nbytes = 16'($urandom_range(1025, 6000));
            else
                nbytes = 16'($urandom);
            send_req(REQ_ALLOC, nbytes, 16'($urandom), r);
        end
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            calm = (i >= 600 && i < 900);
            random_item();
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        stall_gen++;
        for (int i = 0; i < 60; i++)
        begin
            random_item();
        end
    endtask

    task automatic test_pause_until_drained();
        drain_results();
        for (int i = 0; i < 20; i++)
        begin
            random_item();
        end
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    int stall_seen;
    int stall_left;
    always @(posedge clk)
    begin
        if (stall_gen != stall_seen)
        begin
            stall_seen <= stall_gen;
            stall_left <= 600;
            m_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= calm || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge clk)
    begin
        heap_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected transfer offset", m_tdata, -1);
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata !== want.offset)
                    report_mismatch("result_offset", m_tdata, want.offset);
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        calm = 1'b0;
        stall_gen = 0;
        stall_seen = 0;
        stall_left = 0;
        heap_model_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        test_backpressure();
        test_pause_until_drained();
        test_random(850);
        drain_results();
        repeat (300) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
        begin
            $display("tb: PASS");
        end
        else
        begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
